/* hw/rtl/c_subset_lexer_top_defines.svh */
// Assertion macros shared by the lexer RTL; they expect clk and rst_n in scope.
`ifndef C_SUBSET_LEXER_TOP_DEFINES_SVH
`define C_SUBSET_LEXER_TOP_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define CSL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define CSL_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/csl_pkg.sv */
// Package with the lexer's types, codes, constants and character classifiers.
`timescale 1ns / 1ps

package csl_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int LENGTH_WIDTH_DEF   = 8;
    localparam int QUEUE_DEPTH        = 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INTLIT
    } scan_mode_t;

    // Token kinds as they appear on the kind port.
    localparam logic [3:0] KIND_IDENT    = 4'd0;
    localparam logic [3:0] KIND_INT      = 4'd1;
    localparam logic [3:0] KIND_RETURN   = 4'd2;
    localparam logic [3:0] KIND_INTLIT   = 4'd3;
    localparam logic [3:0] KIND_LBRACE   = 4'd4;
    localparam logic [3:0] KIND_RBRACE   = 4'd5;
    localparam logic [3:0] KIND_LPAREN   = 4'd6;
    localparam logic [3:0] KIND_RPAREN   = 4'd7;
    localparam logic [3:0] KIND_SEMI     = 4'd8;
    localparam logic [3:0] KIND_LBRACKET = 4'd9;
    localparam logic [3:0] KIND_RBRACKET = 4'd10;
    localparam logic [3:0] KIND_COMMA    = 4'd11;
    localparam logic [3:0] KIND_INVALID  = 4'd12;

    // Keyword prefix tracker: the prefixes of "int" and of "return".
    localparam logic [3:0] KW_NONE   = 4'd0;
    localparam logic [3:0] KW_I      = 4'd1;
    localparam logic [3:0] KW_IN     = 4'd2;
    localparam logic [3:0] KW_INT    = 4'd3;
    localparam logic [3:0] KW_R      = 4'd4;
    localparam logic [3:0] KW_RE     = 4'd5;
    localparam logic [3:0] KW_RET    = 4'd6;
    localparam logic [3:0] KW_RETU   = 4'd7;
    localparam logic [3:0] KW_RETUR  = 4'd8;
    localparam logic [3:0] KW_RETURN = 4'd9;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
    } tok_t;

    // All tokens caused by one input byte; the head is always present.
    typedef struct packed {
        tok_t head;
        logic tail_valid;
        tok_t tail;
    } pkt_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == "{" || c == "}" || c == "(" || c == ")" ||
               c == ";" || c == "[" || c == "]" || c == ",";
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            ",":     k = KIND_COMMA;
            default: k = KIND_INVALID;
        endcase
        return k;
    endfunction

    // Advances the keyword prefix by one identifier byte.
    function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
        logic [3:0] n;
        n = KW_NONE;
        if ((p == KW_I && c == "n") || (p == KW_IN && c == "t") ||
            (p == KW_R && c == "e") || (p == KW_RE && c == "t") ||
            (p == KW_RET && c == "u") || (p == KW_RETU && c == "r") ||
            (p == KW_RETUR && c == "n"))
        begin
            n = p + 4'd1;
        end
        return n;
    endfunction

endpackage

/* hw/rtl/csl_front.sv */
// Front end: takes source bytes, tracks position and the open token, builds token packets.
`timescale 1ns / 1ps

module csl_front #(
    parameter int POSITION_WIDTH = csl_pkg::POSITION_WIDTH_DEF,
    parameter int LENGTH_WIDTH   = csl_pkg::LENGTH_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    ch,
    input  logic          end_of_text,
    output logic          push_valid,
    input  logic          push_ready,
    output csl_pkg::pkt_t push_pkt
);
    import csl_pkg::*;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX = {LENGTH_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0]   LEN_ONE = LENGTH_WIDTH'(1);

    scan_mode_t                mode_reg, mode_next, mode_mid;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] col_reg, col_next;
    logic [POSITION_WIDTH-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_WIDTH-1:0] tok_col_reg, tok_col_next;
    logic [LENGTH_WIDTH-1:0]   tok_len_reg, tok_len_next;
    logic [3:0]                kw_reg, kw_next_val;

    logic is_zero, letter, digit, consumed, pending;
    logic flush_valid, single_valid, last_valid, tail_any, accept;
    tok_t flush_tok, single_tok, last_tok, tail_tok;

    function automatic logic [15:0] sat_pos(input logic [POSITION_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [7:0] sat_len(input logic [LENGTH_WIDTH-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return (w > 16'h00FF) ? 8'hFF : w[7:0];
    endfunction

    function automatic logic [3:0] ident_kind(input logic [3:0] kw);
        return (kw == KW_INT) ? KIND_INT : ((kw == KW_RETURN) ? KIND_RETURN : KIND_IDENT);
    endfunction

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_zero  = (ch == CH_NUL);
        letter   = is_letter(ch);
        digit    = is_digit(ch);
        pending  = (mode_reg == MODE_IDENT) || (mode_reg == MODE_INTLIT);
        consumed = !is_zero && (((mode_reg == MODE_IDENT) && (letter || digit)) ||
                                ((mode_reg == MODE_INTLIT) && digit));

        // The open token is closed by any byte that does not continue it.
        flush_valid      = pending && !consumed;
        flush_tok.kind   = (mode_reg == MODE_IDENT) ? ident_kind(kw_reg) : KIND_INTLIT;
        flush_tok.line   = sat_pos(tok_line_reg);
        flush_tok.column = sat_pos(tok_col_reg);
        flush_tok.length = sat_len(tok_len_reg);

        // Punctuation and unknown bytes are one-byte tokens of their own.
        single_valid      = !is_zero && !consumed && !letter && !digit && !is_space(ch);
        single_tok.kind   = is_punct(ch) ? punct_kind(ch) : KIND_INVALID;
        single_tok.line   = sat_pos(line_reg);
        single_tok.column = sat_pos(col_reg);
        single_tok.length = 8'd1;

        // Open-token state after this byte, before the end-of-text flush.
        mode_mid      = MODE_IDLE;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_len_next  = tok_len_reg;
        kw_next_val   = KW_NONE;
        if (consumed)
        begin
            mode_mid     = mode_reg;
            tok_len_next = (tok_len_reg != LEN_MAX) ? tok_len_reg + LEN_ONE : tok_len_reg;
            kw_next_val  = kw_next(kw_reg, ch);
        end
        else if (!is_zero && (letter || digit))
        begin
            mode_mid      = letter ? MODE_IDENT : MODE_INTLIT;
            tok_line_next = line_reg;
            tok_col_next  = col_reg;
            tok_len_next  = LEN_ONE;
            if (letter && ch == "i")
            begin
                kw_next_val = KW_I;
            end
            else if (letter && ch == "r")
            begin
                kw_next_val = KW_R;
            end
        end

        last_valid      = !is_zero && end_of_text && (mode_mid != MODE_IDLE);
        last_tok.kind   = (mode_mid == MODE_IDENT) ? ident_kind(kw_next_val) : KIND_INTLIT;
        last_tok.line   = sat_pos(tok_line_next);
        last_tok.column = sat_pos(tok_col_next);
        last_tok.length = sat_len(tok_len_next);

        tail_any = single_valid || last_valid;
        tail_tok = single_valid ? single_tok : last_tok;

        push_valid          = in_valid && (flush_valid || tail_any);
        push_pkt.head       = flush_valid ? flush_tok : tail_tok;
        push_pkt.tail_valid = flush_valid && tail_any;
        push_pkt.tail       = tail_tok;

        // Position counters.
        if (is_zero || end_of_text)
        begin
            mode_next = MODE_IDLE;
            line_next = POS_ONE;
            col_next  = POS_ONE;
        end
        else
        begin
            mode_next = mode_mid;
            if (ch == CH_NEWLINE)
            begin
                line_next = (line_reg != POS_MAX) ? line_reg + POS_ONE : line_reg;
                col_next  = POS_ONE;
            end
            else
            begin
                line_next = line_reg;
                col_next  = (col_reg != POS_MAX) ? col_reg + POS_ONE : col_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= POS_ONE;
            col_reg  <= POS_ONE;
            kw_reg   <= KW_NONE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            kw_reg   <= kw_next_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_line_reg <= '0;
            tok_col_reg  <= '0;
            tok_len_reg  <= '0;
        end
        else if (accept)
        begin
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_len_reg  <= tok_len_next;
        end
    end

endmodule

/* hw/rtl/csl_queue.sv */
// Small FIFO of token packets between the front end and the back end.
`timescale 1ns / 1ps

module csl_queue #(
    parameter int DEPTH = csl_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  csl_pkg::pkt_t push_pkt,
    output logic          pop_valid,
    input  logic          pop_ready,
    output csl_pkg::pkt_t pop_pkt
);
    import csl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pkt_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_pkt    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

/* hw/rtl/csl_back.sv */
// Back end: holds one packet and hands its tokens out one transfer at a time.
`timescale 1ns / 1ps

module csl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  csl_pkg::pkt_t pop_pkt,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [3:0]    kind,
    output logic [15:0]   start_line,
    output logic [15:0]   start_column,
    output logic [7:0]    length,
    output logic          last_of_run
);
    import csl_pkg::*;

    pkt_t pkt_reg;
    logic full_reg, full_next;
    logic second_reg, second_next;
    logic xfer, finishing, load;
    tok_t cur_tok;

    assign cur_tok      = second_reg ? pkt_reg.tail : pkt_reg.head;
    assign out_valid    = full_reg;
    assign kind         = cur_tok.kind;
    assign start_line   = cur_tok.line;
    assign start_column = cur_tok.column;
    assign length       = cur_tok.length;
    assign last_of_run  = second_reg || !pkt_reg.tail_valid;

    assign xfer      = out_valid && out_ready;
    assign finishing = xfer && last_of_run;
    assign pop_ready = !full_reg || finishing;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        full_next   = full_reg;
        second_next = second_reg;
        if (load)
        begin
            full_next   = 1'b1;
            second_next = 1'b0;
        end
        else if (finishing)
        begin
            full_next   = 1'b0;
            second_next = 1'b0;
        end
        else if (xfer)
        begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            full_reg   <= full_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= pop_pkt;
        end
    end

endmodule

/* hw/rtl/c_subset_lexer_top.sv */
// Top level of the byte-serial lexer for a small C subset.
`timescale 1ns / 1ps
`include "c_subset_lexer_top_defines.svh"

//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------------
//  input   | in_valid / in_ready  | ch, end_of_text
//  output  | out_valid / out_ready| kind, start_line, start_column, length, last_of_run
//
// One source byte is taken per cycle while the queue has room. The front end
// classifies the byte and updates the position counters in the same cycle, so
// bytes can follow each other back to back; every byte that closes or forms
// tokens pushes one packet of one or two tokens into a four-entry queue. The
// back end delivers one token per transfer, so a byte that yields two tokens
// uses the output for two transfers, and the queue absorbs such bursts. A token
// is written into the queue when its byte is transferred and is then loaded
// into the back end's packet register before it is offered on the output.
// Reset is asynchronous and needs no clearing pass; the lexer is ready at once.
// A stall on the output only stops the input once the queue is full.

module c_subset_lexer_top #(
    parameter int POSITION_WIDTH = csl_pkg::POSITION_WIDTH_DEF,
    parameter int LENGTH_WIDTH   = csl_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic [7:0]  length,
    output logic        last_of_run
);
    import csl_pkg::*;

    // Packets of tokens travel from the front end into the queue.
    logic push_valid, push_ready;
    pkt_t push_pkt;

    // The back end pulls packets from the queue as it frees up.
    logic pop_valid, pop_ready;
    pkt_t pop_pkt;

    // The front end owns all scanner state: mode, position, open token and
    // keyword prefix. It only accepts a byte when the queue has room.
    csl_front #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .LENGTH_WIDTH   (LENGTH_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .end_of_text (end_of_text),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_pkt    (push_pkt)
    );

    csl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pkt   (push_pkt),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_pkt    (pop_pkt)
    );

    // The back end splits a packet into its tokens and marks the last one.
    csl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_pkt      (pop_pkt),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .start_line   (start_line),
        .start_column (start_column),
        .length       (length),
        .last_of_run  (last_of_run)
    );

    // Conditions watched by the assertions below.
    logic head_of_pair, tail_shown, token_ok;
    assign head_of_pair = out_valid && out_ready && !last_of_run;
    assign tail_shown   = out_valid && last_of_run;
    assign token_ok     = !out_valid || (kind <= KIND_INVALID && length != 8'd0 &&
                                         start_line != 16'd0 && start_column != 16'd0);

    // A token that is not the last of its byte is always followed by the last one.
    `CSL_ASSERT_NEXT(a_pair_completes, head_of_pair, tail_shown, "second token missing")

    // Every delivered token has a known kind and a nonzero position and length.
    `CSL_ASSERT_ALWAYS(a_token_fields_sane, token_ok, "token fields out of range")

endmodule
